// ===== rtl/closest_approach_two_lines_3d_defines.svh =====
// assertion macros for the closest approach block
// no dependencies; expects clock and reset in the including scope
`ifndef CLOSEST_APPROACH_TWO_LINES_3D_DEFINES_SVH
`define CLOSEST_APPROACH_TWO_LINES_3D_DEFINES_SVH

// same-cycle implication
`define CLA3D_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("cla3d check failed");

// next-cycle implication
`define CLA3D_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("cla3d check failed");

`endif

// ===== rtl/cla3d_pkg.sv =====
// widths, word types, status codes and saturation for the closest approach block
// no dependencies
`timescale 1ns / 1ps

package cla3d_pkg;

   localparam int COORD_W    = 32;
   localparam int DIFF_W     = COORD_W + 1;
   localparam int PROD_W     = 2 * DIFF_W;
   localparam int DOT_W      = PROD_W + 2;
   localparam int PAIR_W     = 2 * DOT_W;
   localparam int TERM_W     = PAIR_W + 1;
   localparam int DEN_W      = PAIR_W;
   localparam int NUMER_W    = TERM_W + DIFF_W;
   localparam int QUO_W      = NUMER_W + 2;
   localparam int POINT_W    = QUO_W + 1;
   localparam int SUM_W      = POINT_W + 1;
   localparam int MUL_LAT    = 4;
   localparam int MUL_LIMB_W = 34;
   localparam int DIV_LAT    = NUMER_W + 3;
   localparam int STATUS_W   = 2;

   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_PARALLEL = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_ZERO_B   = 2'd2;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [DIFF_W-1:0]  diff_type;

   typedef struct packed {
      coord_type a_first_x;
      coord_type a_first_y;
      coord_type a_first_z;
      coord_type a_second_x;
      coord_type a_second_y;
      coord_type a_second_z;
      coord_type b_first_x;
      coord_type b_first_y;
      coord_type b_first_z;
      coord_type b_second_x;
      coord_type b_second_y;
      coord_type b_second_z;
   } req_word_type;

   typedef struct packed {
      coord_type near_a_x;
      coord_type near_a_y;
      coord_type near_a_z;
      coord_type near_b_x;
      coord_type near_b_y;
      coord_type near_b_z;
      coord_type mid_x;
      coord_type mid_y;
      coord_type mid_z;
      logic [STATUS_W-1:0] status;
   } rsp_word_type;

   function automatic coord_type sat_coord(input logic signed [SUM_W-1:0] v);
      logic [SUM_W-COORD_W:0] top;
      coord_type r;
      top = v[SUM_W-1:COORD_W-1];
      if ((&top) || !(|top)) r = v[COORD_W-1:0];
      else if (v[SUM_W-1]) r = {1'b1, {(COORD_W-1){1'b0}}};
      else r = {1'b0, {(COORD_W-1){1'b1}}};
      return r;
   endfunction

endpackage

// ===== rtl/cla3d_chan_if.sv =====
// valid/ready channel carrying one word of a given type
// word types come from cla3d_pkg
`timescale 1ns / 1ps

interface cla3d_chan_if #(parameter type word_type = logic);
   logic     valid;
   logic     ready;
   word_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/cla3d_mul.sv =====
// pipelined signed multiplier, sign-magnitude with limb partial products, 4 stages
// depends on cla3d_pkg
`timescale 1ns / 1ps

module cla3d_mul #(
   parameter int A_W = cla3d_pkg::DOT_W,
   parameter int B_W = cla3d_pkg::DOT_W
) (
   input  logic                      clock,
   input  logic                      en,
   input  logic signed [A_W-1:0]     a,
   input  logic signed [B_W-1:0]     b,
   output logic signed [A_W+B_W-1:0] p
);
   import cla3d_pkg::*;

   localparam int LW  = MUL_LIMB_W;
   localparam int A_N = (A_W + LW - 1) / LW;
   localparam int B_N = (B_W + LW - 1) / LW;
   localparam int P_W = A_W + B_W;

   logic [A_W-1:0]    abs_a_in;
   logic [B_W-1:0]    abs_b_in;
   logic [A_N*LW-1:0] mag_a_ff;
   logic [B_N*LW-1:0] mag_b_ff;
   logic [2*LW-1:0]   pp_ff [A_N*B_N];
   logic [P_W-1:0]    sum_in;
   logic [P_W-1:0]    sum_ff;
   logic [2:0]        neg_ff;
   logic signed [P_W-1:0] p_ff;

   always_comb begin
      abs_a_in = a[A_W-1] ? $unsigned(-a) : $unsigned(a);
      abs_b_in = b[B_W-1] ? $unsigned(-b) : $unsigned(b);
   end

   always_comb begin
      sum_in = '0;
      for (int i = 0; i < A_N; i++) begin
         for (int j = 0; j < B_N; j++) begin
            sum_in = sum_in + (P_W'(pp_ff[i*B_N+j]) << (LW * (i + j)));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mag_a_ff  <= (A_N*LW)'(abs_a_in);
         mag_b_ff  <= (B_N*LW)'(abs_b_in);
         neg_ff[0] <= a[A_W-1] ^ b[B_W-1];
         for (int i = 0; i < A_N; i++) begin
            for (int j = 0; j < B_N; j++) begin
               pp_ff[i*B_N+j] <= (2*LW)'(mag_a_ff[i*LW +: LW]) * (2*LW)'(mag_b_ff[j*LW +: LW]);
            end
         end
         neg_ff[1] <= neg_ff[0];
         sum_ff    <= sum_in;
         neg_ff[2] <= neg_ff[1];
         p_ff      <= neg_ff[2] ? -$signed(sum_ff) : $signed(sum_ff);
      end
   end

   assign p = p_ff;

endmodule

// ===== rtl/cla3d_div.sv =====
// pipelined restoring divider, one quotient bit per stage, rounds half away from zero
// depends on cla3d_pkg
`timescale 1ns / 1ps

module cla3d_div #(
   parameter int N_W = cla3d_pkg::NUMER_W,
   parameter int D_W = cla3d_pkg::DEN_W
) (
   input  logic                  clock,
   input  logic                  en,
   input  logic signed [N_W-1:0] num,
   input  logic [D_W-1:0]        den,
   output logic signed [N_W+1:0] quo
);
   import cla3d_pkg::*;

   logic [D_W-1:0] rem_ff [N_W+1];
   logic [N_W-1:0] nq_ff  [N_W+1];
   logic [D_W-1:0] den_ff [N_W+1];
   logic           neg_ff [N_W+1];
   logic [N_W-1:0] mag_in;
   logic           up_in;
   logic [N_W:0]   q1_ff;
   logic           neg_r_ff;
   logic signed [N_W+1:0] quo_ff;

   assign mag_in = num[N_W-1] ? $unsigned(-num) : $unsigned(num);

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= '0;
         nq_ff[0]  <= mag_in;
         den_ff[0] <= den;
         neg_ff[0] <= num[N_W-1];
      end
   end

   for (genvar k = 1; k <= N_W; k++) begin : g_step
      logic [D_W:0]   trial_in;
      logic           fits_in;
      logic [D_W-1:0] rem_in;
      always_comb begin
         trial_in = {rem_ff[k-1], nq_ff[k-1][N_W-1]};
         fits_in  = trial_in >= {1'b0, den_ff[k-1]};
         rem_in   = fits_in ? D_W'(trial_in - {1'b0, den_ff[k-1]}) : D_W'(trial_in);
      end
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= rem_in;
            nq_ff[k]  <= {nq_ff[k-1][N_W-2:0], fits_in};
            den_ff[k] <= den_ff[k-1];
            neg_ff[k] <= neg_ff[k-1];
         end
      end
   end

   assign up_in = {rem_ff[N_W], 1'b0} >= {1'b0, den_ff[N_W]};

   always_ff @(posedge clock) begin
      if (en) begin
         q1_ff    <= {1'b0, nq_ff[N_W]} + (N_W+1)'(up_in);
         neg_r_ff <= neg_ff[N_W];
         quo_ff   <= neg_r_ff ? -$signed({1'b0, q1_ff}) : $signed({1'b0, q1_ff});
      end
   end

   assign quo = quo_ff;

endmodule

// ===== rtl/closest_approach_two_lines_3d.sv =====
// Closest approach of two 3D lines given as point pairs in Q16.16. Takes one
// pair per clock while the pipeline is not halted; each word passes through the
// difference and dot product stages, two 4-stage multiplier banks and the
// divider, which resolves one quotient bit per stage over the 170-bit numerators,
// before it is presented at the output register.
// Parallel lines or a zero-length line B give a status flag and zero points.
// The pipeline keeps advancing into empty slots while a result waits at the
// output register; it halts only when a finished word would be lost.
// depends on cla3d_pkg, cla3d_chan_if, cla3d_mul, cla3d_div and the defines header
`timescale 1ns / 1ps
`include "closest_approach_two_lines_3d_defines.svh"

module closest_approach_two_lines_3d (
   input logic        clock,
   input logic        reset,
   cla3d_chan_if.sink   req_chan,
   cla3d_chan_if.source rsp_chan
);
   import cla3d_pkg::*;

   localparam int T_MUL1 = 3 + MUL_LAT;
   localparam int T_NUM  = T_MUL1 + 1;
   localparam int T_MUL2 = T_NUM + MUL_LAT;
   localparam int T_SUM  = T_MUL2 + DIV_LAT + 1;
   localparam int V_N    = T_SUM;
   localparam int DA_N   = T_NUM;
   localparam int PT_N   = T_MUL2 + DIV_LAT;
   localparam int ZB_N   = MUL_LAT;
   localparam int DEN_N  = MUL_LAT + 1;
   localparam int STAT_N = T_SUM - T_NUM + 1;

   logic en;
   logic out_load;
   logic [V_N-1:0] valid_ff;
   logic out_valid_ff;
   rsp_word_type out_word_ff, out_word_in;

   coord_type a1_in [3], a2_in [3], b1_in [3], b2_in [3];

   diff_type  da_ff [DA_N][3];
   diff_type  db_ff [DA_N][3];
   diff_type  w_ff [3];
   coord_type pa_ff [PT_N][3];
   coord_type pb_ff [PT_N][3];

   logic signed [PROD_W-1:0] p_wb_ff [3], p_ba_ff [3], p_wa_ff [3], p_bb_ff [3], p_aa_ff [3];
   logic signed [DOT_W-1:0]  d1343_ff, d4321_ff, d1321_ff, d4343_ff, d2121_ff;

   logic signed [PAIR_W-1:0] m_aabb, m_baba, m_wbba, m_wabb, m_wbaa, m_waba;
   logic [ZB_N-1:0] zb_ff;

   logic signed [TERM_W-1:0] den_ff [DEN_N];
   logic signed [TERM_W-1:0] numa_ff, numb_ff;
   logic [STATUS_W-1:0] stat_ff [STAT_N];
   logic [STATUS_W-1:0] stat_in;

   logic signed [NUMER_W-1:0] mna [3], mnb [3];
   logic signed [QUO_W-1:0]   qa [3], qb [3];
   logic signed [POINT_W-1:0] na_ff [3], nb_ff [3];
   logic signed [SUM_W-1:0]   mid_in [3];

   assign out_load      = !out_valid_ff || rsp_chan.ready;
   assign en            = !valid_ff[V_N-1] || out_load;
   assign req_chan.ready = en;
   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.data  = out_word_ff;

   always_comb begin
      a1_in[0] = req_chan.data.a_first_x;
      a1_in[1] = req_chan.data.a_first_y;
      a1_in[2] = req_chan.data.a_first_z;
      a2_in[0] = req_chan.data.a_second_x;
      a2_in[1] = req_chan.data.a_second_y;
      a2_in[2] = req_chan.data.a_second_z;
      b1_in[0] = req_chan.data.b_first_x;
      b1_in[1] = req_chan.data.b_first_y;
      b1_in[2] = req_chan.data.b_first_z;
      b2_in[0] = req_chan.data.b_second_x;
      b2_in[1] = req_chan.data.b_second_y;
      b2_in[2] = req_chan.data.b_second_z;
   end

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[V_N-2:0], req_chan.valid};
      end
   end

   // differences, products, dot products
   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            da_ff[0][k] <= DIFF_W'(a2_in[k]) - DIFF_W'(a1_in[k]);
            db_ff[0][k] <= DIFF_W'(b2_in[k]) - DIFF_W'(b1_in[k]);
            w_ff[k]     <= DIFF_W'(a1_in[k]) - DIFF_W'(b1_in[k]);
            pa_ff[0][k] <= a1_in[k];
            pb_ff[0][k] <= b1_in[k];
            for (int i = 1; i < DA_N; i++) begin
               da_ff[i][k] <= da_ff[i-1][k];
               db_ff[i][k] <= db_ff[i-1][k];
            end
            for (int i = 1; i < PT_N; i++) begin
               pa_ff[i][k] <= pa_ff[i-1][k];
               pb_ff[i][k] <= pb_ff[i-1][k];
            end
            p_wb_ff[k] <= w_ff[k] * db_ff[0][k];
            p_ba_ff[k] <= db_ff[0][k] * da_ff[0][k];
            p_wa_ff[k] <= w_ff[k] * da_ff[0][k];
            p_bb_ff[k] <= db_ff[0][k] * db_ff[0][k];
            p_aa_ff[k] <= da_ff[0][k] * da_ff[0][k];
         end
         d1343_ff <= DOT_W'(p_wb_ff[0]) + DOT_W'(p_wb_ff[1]) + DOT_W'(p_wb_ff[2]);
         d4321_ff <= DOT_W'(p_ba_ff[0]) + DOT_W'(p_ba_ff[1]) + DOT_W'(p_ba_ff[2]);
         d1321_ff <= DOT_W'(p_wa_ff[0]) + DOT_W'(p_wa_ff[1]) + DOT_W'(p_wa_ff[2]);
         d4343_ff <= DOT_W'(p_bb_ff[0]) + DOT_W'(p_bb_ff[1]) + DOT_W'(p_bb_ff[2]);
         d2121_ff <= DOT_W'(p_aa_ff[0]) + DOT_W'(p_aa_ff[1]) + DOT_W'(p_aa_ff[2]);
         zb_ff    <= {zb_ff[ZB_N-2:0], d4343_ff == '0};
      end
   end

   cla3d_mul #(.A_W(DOT_W), .B_W(DOT_W)) u_mul_aabb (
      .clock(clock), .en(en), .a(d2121_ff), .b(d4343_ff), .p(m_aabb));
   cla3d_mul #(.A_W(DOT_W), .B_W(DOT_W)) u_mul_baba (
      .clock(clock), .en(en), .a(d4321_ff), .b(d4321_ff), .p(m_baba));
   cla3d_mul #(.A_W(DOT_W), .B_W(DOT_W)) u_mul_wbba (
      .clock(clock), .en(en), .a(d1343_ff), .b(d4321_ff), .p(m_wbba));
   cla3d_mul #(.A_W(DOT_W), .B_W(DOT_W)) u_mul_wabb (
      .clock(clock), .en(en), .a(d1321_ff), .b(d4343_ff), .p(m_wabb));
   cla3d_mul #(.A_W(DOT_W), .B_W(DOT_W)) u_mul_wbaa (
      .clock(clock), .en(en), .a(d1343_ff), .b(d2121_ff), .p(m_wbaa));
   cla3d_mul #(.A_W(DOT_W), .B_W(DOT_W)) u_mul_waba (
      .clock(clock), .en(en), .a(d1321_ff), .b(d4321_ff), .p(m_waba));

   always_comb begin
      if (zb_ff[ZB_N-1]) stat_in = STATUS_ZERO_B;
      else if (m_aabb == m_baba) stat_in = STATUS_PARALLEL;
      else stat_in = STATUS_OK;
   end

   // denominator, numerators, status
   always_ff @(posedge clock) begin
      if (en) begin
         den_ff[0]  <= TERM_W'(m_aabb) - TERM_W'(m_baba);
         numa_ff    <= TERM_W'(m_wbba) - TERM_W'(m_wabb);
         numb_ff    <= TERM_W'(m_wbaa) - TERM_W'(m_waba);
         stat_ff[0] <= stat_in;
         for (int i = 1; i < DEN_N; i++) den_ff[i] <= den_ff[i-1];
         for (int i = 1; i < STAT_N; i++) stat_ff[i] <= stat_ff[i-1];
      end
   end

   for (genvar k = 0; k < 3; k++) begin : g_axis
      cla3d_mul #(.A_W(TERM_W), .B_W(DIFF_W)) u_mul_na (
         .clock(clock), .en(en), .a(numa_ff), .b(da_ff[DA_N-1][k]), .p(mna[k]));
      cla3d_mul #(.A_W(TERM_W), .B_W(DIFF_W)) u_mul_nb (
         .clock(clock), .en(en), .a(numb_ff), .b(db_ff[DA_N-1][k]), .p(mnb[k]));
      cla3d_div #(.N_W(NUMER_W), .D_W(DEN_W)) u_div_a (
         .clock(clock), .en(en), .num(mna[k]), .den(den_ff[DEN_N-1][DEN_W-1:0]),
         .quo(qa[k]));
      cla3d_div #(.N_W(NUMER_W), .D_W(DEN_W)) u_div_b (
         .clock(clock), .en(en), .num(mnb[k]), .den(den_ff[DEN_N-1][DEN_W-1:0]),
         .quo(qb[k]));

      always_ff @(posedge clock) begin
         if (en) begin
            na_ff[k] <= POINT_W'(pa_ff[PT_N-1][k]) + POINT_W'(qa[k]);
            nb_ff[k] <= POINT_W'(pb_ff[PT_N-1][k]) + POINT_W'(qb[k]);
         end
      end

      assign mid_in[k] = (SUM_W'(na_ff[k]) + SUM_W'(nb_ff[k])) >>> 1;
   end

   always_comb begin
      out_word_in.near_a_x = sat_coord(SUM_W'(na_ff[0]));
      out_word_in.near_a_y = sat_coord(SUM_W'(na_ff[1]));
      out_word_in.near_a_z = sat_coord(SUM_W'(na_ff[2]));
      out_word_in.near_b_x = sat_coord(SUM_W'(nb_ff[0]));
      out_word_in.near_b_y = sat_coord(SUM_W'(nb_ff[1]));
      out_word_in.near_b_z = sat_coord(SUM_W'(nb_ff[2]));
      out_word_in.mid_x    = sat_coord(mid_in[0]);
      out_word_in.mid_y    = sat_coord(mid_in[1]);
      out_word_in.mid_z    = sat_coord(mid_in[2]);
      out_word_in.status   = stat_ff[STAT_N-1];
      if (stat_ff[STAT_N-1] != STATUS_OK) begin
         out_word_in = '0;
         out_word_in.status = stat_ff[STAT_N-1];
      end
   end

   // output word register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_load) begin
         out_valid_ff <= valid_ff[V_N-1];
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_word_ff <= out_word_in;
      end
   end

   `CLA3D_ASSERT_IMPL(a_flag_zeroes, out_valid_ff && out_word_ff.status != STATUS_OK, out_word_ff.mid_x == 0 && out_word_ff.near_a_x == 0 && out_word_ff.near_b_z == 0)
   `CLA3D_ASSERT_NEXT(a_last_held, valid_ff[V_N-1] && !out_load, valid_ff[V_N-1] && $stable(na_ff[0]))
   `CLA3D_ASSERT_NEXT(a_out_drains, out_valid_ff && rsp_chan.ready && !valid_ff[V_N-1], !out_valid_ff)

endmodule

// ===== bench/tb_closest_approach_two_lines_3d.sv =====
// self-checking bench for closest_approach_two_lines_3d: directed and random track pairs
// an exact wide-integer predictor in a scoreboard class checks every result word
// depends on cla3d_pkg, cla3d_chan_if and the closest_approach_two_lines_3d rtl
`timescale 1ns / 1ps

module tb_closest_approach_two_lines_3d;
   import cla3d_pkg::*;

   typedef logic signed [255:0] wide_type;

   localparam int RANDOM_PAIRS = 1430;
   localparam int HOLD_CYCLES  = 600;
   localparam int DRAIN_CYCLES = 400;
   localparam int WATCH_LIMIT  = 6000;

   class approach_board;
      rsp_word_type pending[$];
      int           errors = 0;

      function automatic coord_type clamp(wide_type v);
         if (v > 256'sh7fffffff) return 32'sh7fffffff;
         if (v < -256'sh80000000) return 32'sh80000000;
         return coord_type'(v[31:0]);
      endfunction

      // round to nearest, ties away from zero
      function automatic wide_type div_round(wide_type n, wide_type d);
         wide_type an, ad, q, r;
         an = (n < 0) ? -n : n;
         ad = (d < 0) ? -d : d;
         q  = an / ad;
         r  = an % ad;
         if ((r <<< 1) >= ad) q = q + 1;
         return ((n < 0) != (d < 0)) ? -q : q;
      endfunction

      function automatic rsp_word_type closest_points(req_word_type w);
         wide_type a1[3], b1[3], da[3], db[3], off[3];
         wide_type bb, aa, ba, ob, oa, den, num_a, num_b, na, nb, mid;
         rsp_word_type r;
         coord_type c[12];
         for (int i = 0; i < 12; i++) c[i] = w[(11-i)*32 +: 32];
         bb = 0; aa = 0; ba = 0; ob = 0; oa = 0;
         for (int k = 0; k < 3; k++) begin
            a1[k]  = c[k];
            b1[k]  = c[6+k];
            da[k]  = wide_type'(c[3+k]) - a1[k];
            db[k]  = wide_type'(c[9+k]) - b1[k];
            off[k] = a1[k] - b1[k];
            bb += db[k] * db[k];
            aa += da[k] * da[k];
            ba += db[k] * da[k];
            ob += off[k] * db[k];
            oa += off[k] * da[k];
         end
         r = '0;
         den = aa * bb - ba * ba;
         if (bb == 0) begin
            r.status = STATUS_ZERO_B;
            return r;
         end
         if (den == 0) begin
            r.status = STATUS_PARALLEL;
            return r;
         end
         num_a = ob * ba - oa * bb;
         num_b = ob * aa - oa * ba;
         for (int k = 0; k < 3; k++) begin
            na  = a1[k] + div_round(num_a * da[k], den);
            nb  = b1[k] + div_round(num_b * db[k], den);
            mid = (na + nb) >>> 1;
            r[(8-k)*32+2 +: 32] = clamp(na);
            r[(5-k)*32+2 +: 32] = clamp(nb);
            r[(2-k)*32+2 +: 32] = clamp(mid);
         end
         r.status = STATUS_OK;
         return r;
      endfunction

      function void note_pair(req_word_type w);
         pending = {pending, closest_points(w)};
      endfunction

      function void check_word(rsp_word_type got);
         rsp_word_type want;
         if (pending.size() == 0) begin
            $display("%0t: unexpected word %h", $realtime, got);
            errors++;
            return;
         end
         want = pending.pop_front();
         for (int f = 0; f < 9; f++)
            if (got[f*32+2 +: 32] !== want[f*32+2 +: 32]) begin
               $display("%0t: coord field %0d expected %h actual %h", $realtime, 8 - f,
                        want[f*32+2 +: 32], got[f*32+2 +: 32]);
               errors++;
            end
         if (got.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $realtime, want.status, got.status);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   cla3d_chan_if #(.word_type(req_word_type)) req_chan ();
   cla3d_chan_if #(.word_type(rsp_word_type)) rsp_chan ();

   closest_approach_two_lines_3d i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   approach_board board = new();
   bit  quiet_period = 1'b0;
   bit  hold_request = 1'b0;
   int  idle_cycles  = 0;

   always #1 clock = ~clock;

   task automatic send_pair(input coord_type c[12]);
      req_word_type w;
      for (int i = 0; i < 12; i++) w[(11-i)*32 +: 32] = c[i];
      while (!quiet_period && $urandom_range(0, 99) < 24) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.data  <= w;
      do @(posedge clock); while (!req_chan.ready);
      board.note_pair(w);
   endtask

   function automatic coord_type pick_extreme();
      case ($urandom_range(0, 4))
         0: return 32'sh80000000;
         1: return 32'sh7fffffff;
         2: return 32'sh0;
         3: return -32'sh1;
         default: return 32'sh1;
      endcase
   endfunction

   function automatic coord_type small_val(int span);
      return coord_type'($signed($urandom_range(0, 2 * span)) - span);
   endfunction

   // one random track pair, mostly well-formed geometry
   task automatic send_random();
      coord_type c[12];
      int kind, scale;
      kind = $urandom_range(0, 99);
      for (int i = 0; i < 12; i++) c[i] = small_val(1 << 20);
      if (kind < 40) begin
      end else if (kind < 62) begin
         for (int i = 0; i < 12; i++) c[i] = $urandom;
      end else if (kind < 72) begin
         scale = $urandom_range(1, 3) * ($urandom_range(0, 1) ? 1 : -1);
         for (int k = 0; k < 3; k++) c[9+k] = c[6+k] + scale * (c[3+k] - c[k]);
      end else if (kind < 79) begin
         for (int k = 0; k < 3; k++) c[9+k] = c[6+k];
      end else if (kind < 85) begin
         for (int k = 0; k < 3; k++) c[3+k] = c[k];
      end else if (kind < 93) begin
         // nearly parallel lines meet far away
         for (int k = 0; k < 3; k++) c[9+k] = c[6+k] + (c[3+k] - c[k]) + small_val(1);
      end else begin
         for (int i = 0; i < 12; i++) c[i] = pick_extreme();
      end
      send_pair(c);
   endtask

   task automatic send_directed();
      coord_type c[12];
      for (int i = 0; i < 12; i++) c[i] = 0;
      send_pair(c);
      for (int i = 0; i < 12; i++) c[i] = (i % 2) ? 32'sh7fffffff : 32'sh80000000;
      send_pair(c);
      for (int i = 0; i < 12; i++) c[i] = 32'sh7fffffff;
      c[9] = 32'sh80000000;
      send_pair(c);
      for (int i = 0; i < 12; i++) c[i] = 32'sh80000000;
      c[3] = 32'sh7fffffff; c[10] = 32'sh7fffffff;
      send_pair(c);
      // skew lines along x and y axes
      c = '{0, 0, 0, 32'sh10000, 0, 0, 0, 0, 32'sh20000, 0, 32'sh10000, 32'sh20000};
      send_pair(c);
      // parallel lines
      c = '{0, 0, 0, 32'sh10000, 0, 0, 0, 32'sh10000, 0, 32'sh30000, 32'sh10000, 0};
      send_pair(c);
      // zero-length line a
      c = '{5, 6, 7, 5, 6, 7, 1, 2, 3, 9, 8, 7};
      send_pair(c);
      // zero-length line b
      c = '{1, 2, 3, 4, 5, 6, 7, 8, 9, 7, 8, 9};
      send_pair(c);
      // far intersection, needs saturation
      c = '{0, 0, 0, 32'sh10000, 0, 0, 0, 32'sh1, 0, 32'sh10000, 32'sh2, 32'sh1};
      send_pair(c);
      c = '{32'sh7fff0000, 0, 0, 32'sh7fffffff, 1, 0, 32'sh80000000, 0, 0,
            32'sh80000001, 1, 1};
      send_pair(c);
      for (int n = 0; n < 10; n++) begin
         for (int i = 0; i < 12; i++) c[i] = pick_extreme();
         send_pair(c);
      end
   endtask

   // result side: random stalls, plus one long hold-off on request
   initial begin
      int held;
      rsp_chan.ready = 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (rsp_chan.valid && rsp_chan.ready) board.check_word(rsp_chan.data);
         if (hold_request) begin
            rsp_chan.ready <= 1'b0;
            for (held = 1; held < HOLD_CYCLES; held++) @(posedge clock);
            hold_request = 1'b0;
         end else begin
            rsp_chan.ready <= quiet_period || ($urandom_range(0, 99) >= 24);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCH_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      req_chan.valid = 1'b0;
      req_chan.data  = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_directed();
      hold_request = 1'b1;
      for (int n = 0; n < RANDOM_PAIRS; n++) begin
         quiet_period = (n >= 500 && n < 800);
         send_random();
      end
      req_chan.valid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.errors == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
